FILE: rtl/cfge_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfge_pkg
// types and constants shared by the continued fraction evaluator
// ----------------------------------------------------------------------------
package cfge_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_CHEM_POTENTIAL = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BRANCH_MODE    = 1'd1;

   typedef struct packed {
      logic signed [31:0] alpha_coef;
      logic signed [31:0] beta_coef;
      logic signed [31:0] gamma_coef;
      logic signed [31:0] freq_re;
      logic signed [31:0] freq_im;
      logic signed [31:0] weight;
      logic               last_level;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0] green_re;
      logic signed [31:0] green_im;
      logic               zero_denominator;
   } rsp_item_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_BG, ST_T, ST_DEN, ST_MAG, ST_DIV, ST_FIX, ST_GREEN, ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic do_bg;
      logic do_t;
      logic do_den;
      logic do_mag;
      logic div_start;
      logic div_step;
      logic do_fix;
      logic do_green;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic last;
   } sts_type;

   // saturate a 72-bit signed value to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [71:0] x);
      logic signed [71:0] mx;
      logic signed [71:0] mn;
      mx = 72'sh7FFFFFFF;
      mn = -72'sh80000000;
      if (x > mx) sat32 = 32'sh7FFFFFFF;
      else if (x < mn) sat32 = 32'sh80000000;
      else sat32 = x[31:0];
   endfunction

endpackage

FILE: rtl/cfge_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfge_ctrl
// sequencer for one level: products, denominator, divide, fix; on the last level green value and output
// ----------------------------------------------------------------------------
module cfge_ctrl
   import cfge_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_BG;
         ST_BG:    state_in = ST_T;
         ST_T:     state_in = ST_DEN;
         ST_DEN:   state_in = ST_MAG;
         ST_MAG:   state_in = ST_DIV;
         ST_DIV:   if (sts.div_done) state_in = ST_FIX;
         ST_FIX:   state_in = sts.last ? ST_GREEN : ST_IDLE;
         ST_GREEN: state_in = ST_OUT;
         ST_OUT:   if (!rsp_stall) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load = req_valid;
         end
         ST_BG:    cmd.do_bg = 1'b1;
         ST_T:     cmd.do_t = 1'b1;
         ST_DEN:   cmd.do_den = 1'b1;
         ST_MAG:   begin cmd.do_mag = 1'b1; cmd.div_start = 1'b1; end
         ST_DIV:   cmd.div_step = 1'b1;
         ST_FIX:   cmd.do_fix = 1'b1;
         ST_GREEN: cmd.do_green = 1'b1;
         ST_OUT: begin
            rsp_valid = 1'b1;
            cmd.clear = !rsp_stall;
         end
         default: ;
      endcase
   end

endmodule

FILE: rtl/cfge_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfge_datapath
// fixed-point products, denominator and a serial two-quotient divider
// ----------------------------------------------------------------------------
module cfge_datapath
   import cfge_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output sts_type              sts,
   input  req_item_type         req_item,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata,
   output rsp_item_type         rsp_item
);

   localparam int STEPS = 32 + 2 * FRAC_BITS;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic signed [31:0] chem_ff;
   logic               branch_ff;
   logic signed [31:0] run_re_ff, run_im_ff;
   logic               zseen_ff;
   req_item_type       item_ff;
   logic signed [31:0] bg_ff, t_re_ff, t_im_ff, d_re_ff, d_im_ff;
   logic [63:0]        m_ff;
   logic [31:0]        a_re_ff, a_im_ff;
   logic [63:0]        r_re_ff, r_im_ff;
   logic [32:0]        q_re_ff, q_im_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               zden_ff;
   logic signed [31:0] g_re_ff, g_im_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chem_ff <= '0;
         branch_ff <= 1'b0;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_CHEM_POTENTIAL) chem_ff <= csr_wdata;
         else if (csr_index == CSR_BRANCH_MODE) branch_ff <= csr_wdata[0];
      end
   end

   function automatic logic signed [31:0] fxm(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b);
      fxm = sat32(72'(p >>> FRAC_BITS));
   endfunction

   // one restoring step; q saturates at 2^32
   function automatic logic [97:0] dstep(input logic [63:0] r, input logic [32:0] q,
                                         input logic b, input logic [63:0] m);
      logic [64:0] rr;
      logic [33:0] qq;
      rr = {r, b};
      qq = {q, 1'b0};
      if (rr >= {1'b0, m}) begin
         rr = rr - {1'b0, m};
         qq[0] = 1'b1;
      end
      if (qq > 34'h100000000) qq = 34'h100000000;
      dstep = {rr[63:0], qq[32:0], 1'b0};
   endfunction

   logic        bit_re, bit_im;
   logic [97:0] st_re, st_im;
   logic [CNT_W-1:0] idx;
   always_comb begin
      idx = CNT_W'(STEPS - 1) - cnt_ff;
      bit_re = (idx >= CNT_W'(2 * FRAC_BITS)) ?
               a_re_ff[5'(idx - CNT_W'(2 * FRAC_BITS))] : 1'b0;
      bit_im = (idx >= CNT_W'(2 * FRAC_BITS)) ?
               a_im_ff[5'(idx - CNT_W'(2 * FRAC_BITS))] : 1'b0;
      st_re = dstep(r_re_ff, q_re_ff, bit_re, m_ff);
      st_im = dstep(r_im_ff, q_im_ff, bit_im, m_ff);
   end

   logic signed [71:0] dre_sum, dim_sum;
   always_comb begin
      dre_sum = 72'(item_ff.freq_re) + 72'(chem_ff) - 72'(t_re_ff)
              + (branch_ff ? -72'(item_ff.alpha_coef) : 72'(item_ff.alpha_coef));
      dim_sum = 72'(item_ff.freq_im) - 72'(t_im_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) item_ff <= req_item;
      if (cmd.do_bg) bg_ff <= fxm(item_ff.beta_coef, item_ff.gamma_coef);
      if (cmd.do_t) begin
         t_re_ff <= fxm(bg_ff, run_re_ff);
         t_im_ff <= fxm(bg_ff, run_im_ff);
      end
      if (cmd.do_den) begin
         d_re_ff <= sat32(dre_sum);
         d_im_ff <= sat32(dim_sum);
      end
      if (cmd.do_mag) begin
         m_ff <= 64'(d_re_ff * d_re_ff) + 64'(d_im_ff * d_im_ff);
         a_re_ff <= d_re_ff[31] ? 32'(-d_re_ff) : d_re_ff;
         a_im_ff <= d_im_ff[31] ? 32'(-d_im_ff) : d_im_ff;
         zden_ff <= (d_re_ff == 0) && (d_im_ff == 0);
      end
      if (cmd.div_start) begin
         r_re_ff <= '0; r_im_ff <= '0; q_re_ff <= '0; q_im_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         r_re_ff <= st_re[97:34]; q_re_ff <= st_re[33:1];
         r_im_ff <= st_im[97:34]; q_im_ff <= st_im[33:1];
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
      if (cmd.do_green) begin
         g_re_ff <= fxm(run_re_ff, item_ff.weight);
         g_im_ff <= fxm(run_im_ff, item_ff.weight);
      end
   end

   // running value; im numerator is -den_im so its sign flips
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         run_re_ff <= '0;
         run_im_ff <= '0;
         zseen_ff <= 1'b0;
      end else if (cmd.do_fix) begin
         if (zden_ff) begin
            run_re_ff <= 32'sh7FFFFFFF;
            run_im_ff <= '0;
            zseen_ff <= 1'b1;
         end else begin
            run_re_ff <= d_re_ff[31] ? sat32(-72'(q_re_ff)) : sat32(72'(q_re_ff));
            run_im_ff <= (d_im_ff > 0) ? sat32(-72'(q_im_ff)) : sat32(72'(q_im_ff));
         end
      end
   end

   assign sts.div_done = (cnt_ff == CNT_W'(STEPS - 1)) && cmd.div_step;
   assign sts.last = item_ff.last_level;
   assign rsp_item.green_re = g_re_ff;
   assign rsp_item.green_im = g_im_ff;
   assign rsp_item.zero_denominator = zseen_ff;

endmodule

FILE: rtl/continued_fraction_green_eval_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// continued_fraction_green_eval_unit
// evaluates a continued fraction one level per item, deepest level first
// ----------------------------------------------------------------------------
// sequence: the last level runs through the BG, T, DEN, MAG, DIV, FIX and GREEN states
// before the result is offered in ST_OUT, which holds it while rsp_stall is high
// acceptance: a new item is taken only in ST_IDLE, once the previous item is done;
// the serial restoring divider yields one quotient bit per cycle for both parts
// reset (synchronous) clears the CSR registers, the sequencer state and the running value
module continued_fraction_green_eval_unit
   import cfge_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_item_type         req_item,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_item_type         rsp_item,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   cfge_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .sts(sts), .cmd(cmd)
   );

   cfge_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts), .req_item(req_item),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .rsp_item(rsp_item)
   );

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for continued_fraction_green_eval_unit: fractions of
// coefficient items are driven with random gaps, a bit-exact fixed-point
// model predicts every green value and flag, and a monitor compares results
// ----------------------------------------------------------------------------
module tb
   import cfge_pkg::*;
();

   localparam int FB = FRAC_BITS_DEF;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 120;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_item_type         req_item;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_item_type         rsp_item;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0]          csr_wdata;

   // model state
   longint       mdl_mu;
   bit           mdl_attach;
   longint       mdl_run_re;
   longint       mdl_run_im;
   bit           mdl_zero_seen;
   rsp_item_type green_q[$];

   int  errors;
   int  items_sent;
   int  greens_seen;
   int  zero_flags_seen;
   int  quiet_cycles;
   bit  calm;

   continued_fraction_green_eval_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint clamp32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic longint fx_mul(longint a, longint b);
      longint p;
      p = a * b;
      return clamp32(p >>> FB);
   endfunction

   // sign(n) * min(floor(|n| * 2^(2F) / m), 2^32), then saturated
   function automatic longint recip_part(longint n, logic [127:0] m);
      logic [127:0] mag;
      logic [127:0] q;
      mag = (n < 0) ? 128'(-n) : 128'(n);
      q = (mag << (2 * FB)) / m;
      if (q > 128'h1_0000_0000) q = 128'h1_0000_0000;
      return (n < 0) ? clamp32(-longint'(q)) : clamp32(longint'(q));
   endfunction

   // advance the running value by one level and queue a green value on the last
   task automatic predict_level(req_item_type it);
      longint bg, t_re, t_im, a_term, d_re, d_im;
      logic [127:0] m;
      rsp_item_type g;
      bg = fx_mul(longint'(it.beta_coef), longint'(it.gamma_coef));
      t_re = fx_mul(bg, mdl_run_re);
      t_im = fx_mul(bg, mdl_run_im);
      a_term = mdl_attach ? -longint'(it.alpha_coef) : longint'(it.alpha_coef);
      d_re = clamp32(longint'(it.freq_re) + mdl_mu + a_term - t_re);
      d_im = clamp32(longint'(it.freq_im) - t_im);
      if (d_re == 0 && d_im == 0) begin
         mdl_run_re = 64'sd2147483647;
         mdl_run_im = 0;
         mdl_zero_seen = 1'b1;
      end else begin
         m = 128'(d_re * d_re) + 128'(d_im * d_im);
         mdl_run_re = recip_part(d_re, m);
         mdl_run_im = recip_part(-d_im, m);
      end
      if (it.last_level) begin
         g.green_re = 32'(fx_mul(mdl_run_re, longint'(it.weight)));
         g.green_im = 32'(fx_mul(mdl_run_im, longint'(it.weight)));
         g.zero_denominator = mdl_zero_seen;
         green_q = {green_q, g};
         mdl_run_re = 0;
         mdl_run_im = 0;
         mdl_zero_seen = 1'b0;
      end
   endtask

   // called at a falling edge, returns at a falling edge
   task automatic send_item(req_item_type it);
      while (!calm && $urandom_range(0, 99) < 11) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_item = it;
      do @(posedge clock); while (req_stall);
      predict_level(it);
      items_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] data);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
      if (idx == CSR_CHEM_POTENTIAL) mdl_mu = longint'(signed'(data));
      else if (idx == CSR_BRANCH_MODE) mdl_attach = data[0];
   endtask

   // all results in, then room for a level that produces no result
   task automatic wait_idle();
      while (green_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [31:0] rand_fx();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) return 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
      if (pick < 8) return 32'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000;
      return $urandom;
   endfunction

   function automatic req_item_type make_level(bit last, bit noise);
      req_item_type it;
      it.alpha_coef = noise ? $urandom : rand_fx();
      it.beta_coef  = noise ? $urandom : rand_fx();
      it.gamma_coef = noise ? $urandom : rand_fx();
      it.freq_re    = noise ? $urandom : rand_fx();
      it.freq_im    = noise ? $urandom : 32'($urandom_range(0, 32'h0002_0000));
      it.weight     = noise ? $urandom : rand_fx();
      it.last_level = last;
      return it;
   endfunction

   function automatic req_item_type level_of(int a, int b, int g, int fr, int fi,
                                             int w, bit last);
      req_item_type it;
      it.alpha_coef = a; it.beta_coef = b; it.gamma_coef = g;
      it.freq_re = fr; it.freq_im = fi; it.weight = w; it.last_level = last;
      return it;
   endfunction

   task automatic test_reset_defaults();
      // registers at reset: mu = 0, ionization branch
      send_item(level_of(32'h0001_0000, 32'h0000_8000, 32'h0000_8000,
                         32'h0002_0000, 32'h0000_1000, 32'h0001_0000, 1'b0));
      send_item(level_of(32'hFFFF_0000, 32'h0001_0000, 32'h0002_0000,
                         32'h0002_0000, 32'h0000_1000, 32'h0000_C000, 1'b1));
      wait_idle();
   endtask

   task automatic test_zero_denominator();
      // zero in a single-level fraction, then zero at the deepest level carried into the next level
      send_item(level_of(0, 0, 0, 0, 0, 32'h0001_0000, 1'b1));
      send_item(level_of(32'h0001_0000, 0, 0, 32'hFFFF_0000, 0, 32'h0001_0000, 1'b0));
      send_item(level_of(32'h0001_0000, 32'h0001_0000, 32'h0000_0001,
                         32'h0003_0000, 32'h0000_0100, 32'h0000_0100, 1'b1));
      // weight of zero on a saturated value
      send_item(level_of(0, 32'h7FFF_FFFF, 0, 0, 0, 0, 1'b1));
      wait_idle();
   endtask

   task automatic test_extremes();
      int i;
      write_reg(CSR_CHEM_POTENTIAL, 32'h7FFF_FFFF);
      send_item(level_of(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
      send_item(level_of(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1));
      wait_idle();
      write_reg(CSR_CHEM_POTENTIAL, 32'h8000_0000);
      send_item(level_of(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                         32'h8000_0000, 32'h0000_0001, 32'h8000_0000, 1'b0));
      send_item(level_of(32'h7FFF_FFFF, 32'h0001_0000, 32'h0001_0000,
                         32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
      // a saturated negative denominator drives the reciprocal toward zero
      send_item(level_of(0, 0, 0, 32'h8000_0001, 0, 32'h0001_0000, 1'b1));
      wait_idle();
      write_reg(CSR_CHEM_POTENTIAL, 0);
      for (i = 0; i < 4; i++)
         send_item(level_of(0, 0, 0, (i < 2) ? 1 : -1, (i % 2) ? 1 : -1,
                            32'h7FFF_FFFF, 1'b1));
      wait_idle();
   endtask

   task automatic test_branch_modes();
      // upper bits of the write data are ignored
      write_reg(CSR_BRANCH_MODE, 32'hFFFF_FFFF);
      write_reg(CSR_CHEM_POTENTIAL, 32'h0000_8000);
      send_item(level_of(32'h0002_0000, 32'h0001_0000, 32'h0001_0000,
                         32'h0001_0000, 32'h0000_2000, 32'h0001_0000, 1'b0));
      send_item(level_of(32'h0001_8000, 0, 0, 32'h0001_8000, 32'hFFFF_F000,
                         32'h0002_0000, 1'b1));
      // alpha cancels freq + mu exactly in the attachment branch
      send_item(level_of(32'h0001_8000, 0, 0, 32'h0001_0000, 0, 32'h0001_0000, 1'b1));
      wait_idle();
      write_reg(CSR_BRANCH_MODE, 32'hFFFF_FFFE);
      send_item(level_of(32'hFFFE_8000, 0, 0, 32'h0001_0000, 0, 32'h0001_0000, 1'b1));
      wait_idle();
   endtask

   task automatic test_random_fractions();
      int depth, lv, n, phase;
      bit noise;
      n = 0;
      phase = 0;
      while (n < 1500) begin
         // a new register setting every so often, with a calm stretch in the middle
         if (n >= phase * 250) begin
            wait_idle();
            calm = (phase == 3);
            write_reg(CSR_CHEM_POTENTIAL, (phase % 3 == 2) ? $urandom : rand_fx());
            write_reg(CSR_BRANCH_MODE, $urandom);
            phase++;
         end
         noise = ($urandom_range(0, 9) == 0);
         depth = $urandom_range(1, 6);
         for (lv = 0; lv < depth; lv++) begin
            send_item(make_level(lv == depth - 1, noise));
            n++;
         end
      end
      calm = 1'b0;
      wait_idle();
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_item_type exp_g;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (green_q.size() == 0) begin
            $error("unexpected result green_re=%0d green_im=%0d",
                   rsp_item.green_re, rsp_item.green_im);
            errors++;
         end else begin
            exp_g = green_q.pop_front();
            greens_seen++;
            if (exp_g.zero_denominator) zero_flags_seen++;
            if (rsp_item.green_re !== exp_g.green_re) begin
               $error("green_re expected %0d actual %0d", exp_g.green_re,
                      rsp_item.green_re);
               errors++;
            end
            if (rsp_item.green_im !== exp_g.green_im) begin
               $error("green_im expected %0d actual %0d", exp_g.green_im,
                      rsp_item.green_im);
               errors++;
            end
            if (rsp_item.zero_denominator !== exp_g.zero_denominator) begin
               $error("zero_denominator expected %0b actual %0b",
                      exp_g.zero_denominator, rsp_item.zero_denominator);
               errors++;
            end
         end
      end
   end

   // result-side backpressure
   always @(negedge clock) begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < 11);
   end

   // watchdog on cycles with no item moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      mdl_mu = 0;
      mdl_attach = 1'b0;
      mdl_run_re = 0;
      mdl_run_im = 0;
      mdl_zero_seen = 1'b0;
      errors = 0;
      items_sent = 0;
      greens_seen = 0;
      zero_flags_seen = 0;
      calm = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_zero_denominator();
      test_extremes();
      test_branch_modes();
      test_random_fractions();

      $display("sent %0d coefficient items, checked %0d green values (%0d zero-denominator)",
               items_sent, greens_seen, zero_flags_seen);
      $display("covered both branches, extreme potentials and saturating levels");
      if (errors == 0 && green_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches, %0d results never arrived", errors, green_q.size());
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
